FILE: rtl/rrl_pkg.sv
// Shared types, codes and defaults for the round-robin ready list.
package rrl_pkg;

  localparam int unsigned MAX_THREADS_DEF = 64;
  localparam int unsigned SLICE_BITS_DEF  = 32;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned TID_W   = 6;
  localparam int unsigned CTX_W   = 64;
  localparam int unsigned SLICE_W = 32;

  localparam logic [OP_W-1:0] OP_WAKE   = 2'd0;
  localparam logic [OP_W-1:0] OP_SLEEP  = 2'd1;
  localparam logic [OP_W-1:0] OP_SWITCH = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_LINK,
    ST_PICK
  } state_e;

  typedef struct packed {
    logic s_ready;
    logic clr_we;
    logic rd_item;
    logic sw_save;
    logic wake_wr;
    logic wake_link;
    logic sleep_wr;
    logic sw_rd;
    logic pick;
    logic res_idle;
  } ctrl_t;

  typedef struct packed {
    logic in_range;
    logic awake;
    logic tail_nil;
    logic nxt_nil;
    logic clr_last;
  } status_t;

  typedef struct packed {
    logic               valid;
    logic [TID_W-1:0]   thread;
    logic [CTX_W-1:0]   ctx;
    logic [SLICE_W-1:0] slice;
  } result_t;

endpackage

FILE: rtl/rrl_ctrl.sv
// Sequencer that steps each scheduler item through the list memories.
module rrl_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_valid_i,
  input  logic [rrl_pkg::OP_W-1:0]  op_i,
  input  rrl_pkg::status_t          status_i,
  input  logic                      out_free_i,
  output rrl_pkg::state_e           state_o,
  output rrl_pkg::ctrl_t            ctrl_o
);

  rrl_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrl_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rrl_pkg::ST_CLEAR: begin
        if (status_i.clr_last) state_d = rrl_pkg::ST_IDLE;
      end
      rrl_pkg::ST_IDLE: begin
        if (s_valid_i) state_d = rrl_pkg::ST_READ;
      end
      rrl_pkg::ST_READ: begin
        if (op_i == rrl_pkg::OP_SWITCH) begin
          state_d = rrl_pkg::ST_EVAL;
        end else if ((op_i == rrl_pkg::OP_WAKE || op_i == rrl_pkg::OP_SLEEP)
                     && status_i.in_range) begin
          state_d = rrl_pkg::ST_EVAL;
        end else begin
          state_d = rrl_pkg::ST_IDLE;
        end
      end
      rrl_pkg::ST_EVAL: begin
        if (op_i == rrl_pkg::OP_WAKE) begin
          if (!status_i.awake && !status_i.tail_nil) state_d = rrl_pkg::ST_LINK;
          else state_d = rrl_pkg::ST_IDLE;
        end else if (op_i == rrl_pkg::OP_SWITCH) begin
          if (!status_i.nxt_nil) state_d = rrl_pkg::ST_PICK;
          else if (out_free_i) state_d = rrl_pkg::ST_IDLE;
        end else begin
          state_d = rrl_pkg::ST_IDLE;
        end
      end
      rrl_pkg::ST_LINK: begin
        state_d = rrl_pkg::ST_IDLE;
      end
      rrl_pkg::ST_PICK: begin
        if (out_free_i) state_d = rrl_pkg::ST_IDLE;
      end
      default: begin
        state_d = rrl_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    ctrl_o = '0;
    case (state_q)
      rrl_pkg::ST_CLEAR: begin
        ctrl_o.clr_we = 1'b1;
      end
      rrl_pkg::ST_IDLE: begin
        ctrl_o.s_ready = 1'b1;
      end
      rrl_pkg::ST_READ: begin
        if (op_i == rrl_pkg::OP_SWITCH) begin
          ctrl_o.sw_save = 1'b1;
        end else if ((op_i == rrl_pkg::OP_WAKE || op_i == rrl_pkg::OP_SLEEP)
                     && status_i.in_range) begin
          ctrl_o.rd_item = 1'b1;
        end
      end
      rrl_pkg::ST_EVAL: begin
        if (op_i == rrl_pkg::OP_WAKE) begin
          ctrl_o.wake_wr = !status_i.awake;
        end else if (op_i == rrl_pkg::OP_SLEEP) begin
          ctrl_o.sleep_wr = status_i.awake;
        end else if (op_i == rrl_pkg::OP_SWITCH) begin
          ctrl_o.sw_rd    = !status_i.nxt_nil;
          ctrl_o.res_idle = status_i.nxt_nil && out_free_i;
        end
      end
      rrl_pkg::ST_LINK: begin
        ctrl_o.wake_link = 1'b1;
      end
      rrl_pkg::ST_PICK: begin
        ctrl_o.pick = out_free_i;
      end
      default: begin
        ctrl_o = '0;
      end
    endcase
  end

  assign state_o = state_q;

endmodule

FILE: rtl/rrl_store.sv
// Link, context and slice memories with the list pointers and their update logic.
module rrl_store #(
  parameter int unsigned MAX_THREADS = rrl_pkg::MAX_THREADS_DEF,
  parameter int unsigned SLICE_BITS  = rrl_pkg::SLICE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rrl_pkg::ctrl_t               ctrl_i,
  input  logic [rrl_pkg::TID_W-1:0]    thread_i,
  input  logic [rrl_pkg::CTX_W-1:0]    ctx_i,
  output rrl_pkg::status_t             status_o,
  output rrl_pkg::result_t             result_o
);

  localparam int unsigned AW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int unsigned PW = $clog2(MAX_THREADS + 1);
  localparam logic [PW-1:0] NIL = PW'(MAX_THREADS);
  localparam logic [AW-1:0] LAST = AW'(MAX_THREADS - 1);

  logic                  awake_mem [MAX_THREADS];
  logic [PW-1:0]         next_mem  [MAX_THREADS];
  logic [PW-1:0]         prev_mem  [MAX_THREADS];
  logic [rrl_pkg::CTX_W-1:0] saved_mem [MAX_THREADS];
  logic [SLICE_BITS-1:0] slice_mem [MAX_THREADS];

  logic                  awake_rd_q;
  logic [PW-1:0]         next_rd_q, prev_rd_q;
  logic [rrl_pkg::CTX_W-1:0] saved_rd_q;
  logic [SLICE_BITS-1:0] slice_rd_q;

  logic [PW-1:0] head_q, head_d, tail_q, tail_d, run_q, run_d, nxt_q;
  logic [rrl_pkg::CTX_W-1:0] idle_q, idle_d;
  logic [AW-1:0] clr_cnt_q;

  logic [AW-1:0] t_addr;
  logic [PW-1:0] t_ptr, nxt_c;
  logic          run_nil, next_nil, prev_nil;
  logic [SLICE_BITS-1:0] slice_inc;

  assign t_addr    = AW'(thread_i);
  assign t_ptr     = PW'(thread_i);
  assign run_nil   = !(run_q < NIL);
  assign next_nil  = !(next_rd_q < NIL);
  assign prev_nil  = !(prev_rd_q < NIL);
  assign nxt_c     = (!run_nil && !next_nil) ? next_rd_q : head_q;
  assign slice_inc = slice_rd_q + SLICE_BITS'(1);

  assign status_o.in_range = 32'(thread_i) < 32'(MAX_THREADS);
  assign status_o.awake    = awake_rd_q;
  assign status_o.tail_nil = !(tail_q < NIL);
  assign status_o.nxt_nil  = !(nxt_c < NIL);
  assign status_o.clr_last = clr_cnt_q == LAST;

  // Awake flags: cleared by the sweep after reset
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr_we || ctrl_i.wake_wr || ctrl_i.sleep_wr) begin
      awake_mem[ctrl_i.clr_we ? clr_cnt_q : t_addr] <= ctrl_i.wake_wr;
    end
    if (ctrl_i.rd_item) awake_rd_q <= awake_mem[t_addr];
  end

  // Forward links
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wake_wr) begin
      next_mem[t_addr] <= NIL;
    end else if (ctrl_i.wake_link) begin
      next_mem[AW'(tail_q)] <= t_ptr;
    end else if (ctrl_i.sleep_wr && !prev_nil) begin
      next_mem[AW'(prev_rd_q)] <= next_rd_q;
    end
    if (ctrl_i.rd_item || ctrl_i.sw_save) begin
      next_rd_q <= next_mem[ctrl_i.rd_item ? t_addr : AW'(run_q)];
    end
  end

  // Backward links
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wake_wr) begin
      prev_mem[t_addr] <= tail_q;
    end else if (ctrl_i.sleep_wr && !next_nil) begin
      prev_mem[AW'(next_rd_q)] <= prev_rd_q;
    end
    if (ctrl_i.rd_item) prev_rd_q <= prev_mem[t_addr];
  end

  // Saved contexts
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wake_wr) begin
      saved_mem[t_addr] <= ctx_i;
    end else if (ctrl_i.sw_save && !run_nil) begin
      saved_mem[AW'(run_q)] <= ctx_i;
    end
    if (ctrl_i.sw_rd) saved_rd_q <= saved_mem[AW'(nxt_c)];
  end

  // Slice counters
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr_we) begin
      slice_mem[clr_cnt_q] <= '0;
    end else if (ctrl_i.pick) begin
      slice_mem[AW'(nxt_q)] <= slice_inc;
    end
    if (ctrl_i.sw_rd) slice_rd_q <= slice_mem[AW'(nxt_c)];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sw_rd) nxt_q <= nxt_c;
  end

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    run_d  = run_q;
    idle_d = idle_q;
    if (ctrl_i.wake_wr && status_o.tail_nil) begin
      head_d = t_ptr;
      tail_d = t_ptr;
    end
    if (ctrl_i.wake_link) tail_d = t_ptr;
    if (ctrl_i.sleep_wr) begin
      if (next_nil) tail_d = prev_rd_q;
      if (prev_nil) head_d = next_rd_q;
    end
    if (ctrl_i.sw_save && run_nil) idle_d = ctx_i;
    if (ctrl_i.res_idle) run_d = NIL;
    if (ctrl_i.pick) run_d = nxt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= NIL;
      tail_q    <= NIL;
      run_q     <= NIL;
      idle_q    <= '0;
      clr_cnt_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      run_q  <= run_d;
      idle_q <= idle_d;
      if (ctrl_i.clr_we) clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  always_comb begin
    if (ctrl_i.pick) begin
      result_o.valid  = 1'b1;
      result_o.thread = rrl_pkg::TID_W'(nxt_q);
      result_o.ctx    = saved_rd_q;
      result_o.slice  = rrl_pkg::SLICE_W'(slice_inc);
    end else begin
      result_o.valid  = 1'b0;
      result_o.thread = '0;
      result_o.ctx    = idle_q;
      result_o.slice  = '0;
    end
  end

endmodule

FILE: rtl/round_robin_ready_list_unit.sv
// Top level of the round-robin ready list: stream ports, item capture and result register.
//
// The unit keeps the ready list of a round-robin thread scheduler in single-port memories
// (awake flags, forward and backward links, saved contexts, slice counters) and takes one
// item at a time. Each accepted item passes through a read state and an evaluate state; a
// wake that appends to a non-empty list adds a link state, a switch that picks a slot adds
// a pick state, and an unused code or a wake or sleep of an out-of-range slot goes back to
// idle from the read state. A switch waits only while the previous result has not been
// taken. The sequence is set by the memory ports: each item first reads its slot's
// entries, then writes the neighbours that depend on that read, and appending needs a
// second write to the forward-link memory. After reset the unit sweeps the awake flags and
// slice counters to zero, one entry a cycle, through all MAX_THREADS entries, and accepts
// no item until the sweep is done. The result register lets the next item be accepted while
// a switch result still waits downstream.
module round_robin_ready_list_unit #(
  parameter int unsigned MAX_THREADS = rrl_pkg::MAX_THREADS_DEF,
  parameter int unsigned SLICE_BITS  = rrl_pkg::SLICE_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,   // thread_id[5:0], context_handle[69:6], zero[71:70]
  input  logic [1:0]   s_axis_tuser,   // operation[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // chosen_thread[5:0], resume_context[69:6],
                                       // slice_count[101:70], zero[103:102]
  output logic [0:0]   m_axis_tuser    // thread_valid[0]
);

  rrl_pkg::state_e  state;
  rrl_pkg::ctrl_t   ctrl;
  rrl_pkg::status_t status;
  rrl_pkg::result_t result;

  logic [rrl_pkg::OP_W-1:0]  op_q;
  logic [rrl_pkg::TID_W-1:0] thread_q;
  logic [rrl_pkg::CTX_W-1:0] ctx_q;

  logic             s_xfer, out_free, res_load;
  logic             m_valid_q;
  rrl_pkg::result_t m_res_q;

  assign s_axis_tready = ctrl.s_ready;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  // The result register is free once empty or being taken this cycle
  assign out_free = !m_valid_q || m_axis_tready;
  assign res_load = ctrl.pick || ctrl.res_idle;

  // Hold the accepted item for the whole sequence
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      op_q     <= s_axis_tuser;
      thread_q <= s_axis_tdata[5:0];
      ctx_q    <= s_axis_tdata[69:6];
    end
  end

  rrl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .op_i       (op_q),
    .status_i   (status),
    .out_free_i (out_free),
    .state_o    (state),
    .ctrl_o     (ctrl)
  );

  rrl_store #(
    .MAX_THREADS (MAX_THREADS),
    .SLICE_BITS  (SLICE_BITS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .thread_i (thread_q),
    .ctx_i    (ctx_q),
    .status_o (status),
    .result_o (result)
  );

  // Output register: load a fresh result, drop the valid once the transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) m_res_q <= result;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_res_q.valid;
  assign m_axis_tdata  = {2'b00, m_res_q.slice, m_res_q.ctx, m_res_q.thread};

  // A new result never overwrites one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> out_free)
    else $error("result loaded while output register busy");

  // Wake, sleep and unused codes give no result right after acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_xfer && s_axis_tuser != rrl_pkg::OP_SWITCH) |=> !res_load)
    else $error("result produced for a non-switch item");

  // A chosen thread is always a slot that exists
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (32'(m_axis_tdata[5:0]) < 32'(MAX_THREADS)))
    else $error("chosen thread beyond slot range");

  // An idle result carries zero thread and zero slice count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |->
      (m_axis_tdata[5:0] == 6'd0 && m_axis_tdata[101:70] == 32'd0))
    else $error("idle result with non-zero thread or slice");

  // No item is taken during the clearing sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state == rrl_pkg::ST_CLEAR) |-> !s_axis_tready)
    else $error("item accepted during clearing sweep");

endmodule

FILE: bench/round_robin_ready_list_unit_test.sv
// Self-checking testbench for the round-robin ready list unit: directed and random traffic.
module round_robin_ready_list_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Code 3 has no meaning for the unit: it must be swallowed without a result.
  localparam logic [rrl_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int unsigned SLOTS        = rrl_pkg::MAX_THREADS_DEF;
  localparam logic [6:0]  NIL          = 7'(SLOTS);
  localparam int unsigned RANDOM_ITEMS = 1250;

  // One scheduler event as the sender sees it.
  typedef struct {
    logic [rrl_pkg::OP_W-1:0]  op;
    logic [rrl_pkg::TID_W-1:0] tid;
    logic [rrl_pkg::CTX_W-1:0] ctx;
  } sched_item_t;

  // How the result side takes transfers over a stretch of cycles.
  typedef enum int {
    SINK_FREE,
    SINK_CHOPPY,
    SINK_STALLY
  } sink_mode_e;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [71:0]  s_axis_tdata  = '0;  // thread_id[5:0], context_handle[69:6], zero[71:70]
  logic [1:0]   s_axis_tuser  = '0;  // operation[1:0]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;        // chosen_thread[5:0], resume_context[69:6],
                                     // slice_count[101:70], zero[103:102]
  logic [0:0]   m_axis_tuser;        // thread_valid[0]

  round_robin_ready_list_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shadow ready list: the scheduler state as the unit should hold it.
  // Pointers carry a slot number, or NIL for "none".
  // ---------------------------------------------------------------------------
  bit                          slot_awake  [SLOTS];
  logic [6:0]                  fwd_link    [SLOTS];
  logic [6:0]                  back_link   [SLOTS];
  logic [rrl_pkg::CTX_W-1:0]   slot_ctx    [SLOTS];
  logic [rrl_pkg::SLICE_W-1:0] slot_slices [SLOTS];
  logic [6:0]                  list_head = NIL;
  logic [6:0]                  list_tail = NIL;
  logic [6:0]                  run_slot  = NIL;
  logic [rrl_pkg::CTX_W-1:0]   idle_ctx  = '0;

  sched_item_t      item_backlog[$];     // items still to be offered to the unit
  rrl_pkg::result_t expected_picks[$];   // switch results not yet seen on the output

  int unsigned n_wake, n_sleep, n_switch, n_unused;
  int unsigned n_idle_picks, n_stale_picks, n_checked, n_errors;

  // Apply one accepted item to the shadow list; a switch queues the pick it must yield.
  task automatic apply_sched_item(input sched_item_t it);
    logic [6:0]       nb;
    logic [6:0]       pb;
    logic [6:0]       pick;
    rrl_pkg::result_t res;
    case (it.op)
      rrl_pkg::OP_WAKE: begin
        n_wake++;
        // Waking an awake slot changes nothing, not even its context.
        if (!slot_awake[it.tid]) begin
          slot_awake[it.tid] = 1'b1;
          slot_ctx[it.tid]   = it.ctx;
          fwd_link[it.tid]   = NIL;
          back_link[it.tid]  = list_tail;
          if (list_tail != NIL) begin
            fwd_link[list_tail[5:0]] = {1'b0, it.tid};
          end else begin
            list_head = {1'b0, it.tid};
          end
          list_tail = {1'b0, it.tid};
        end
      end
      rrl_pkg::OP_SLEEP: begin
        n_sleep++;
        // Unlink, but leave the removed slot's own links alone: a running slot
        // that falls asleep still steers the next switch through its old successor.
        if (slot_awake[it.tid]) begin
          slot_awake[it.tid] = 1'b0;
          nb = fwd_link[it.tid];
          pb = back_link[it.tid];
          if (nb != NIL) begin
            back_link[nb[5:0]] = pb;
          end else begin
            list_tail = pb;
          end
          if (pb != NIL) begin
            fwd_link[pb[5:0]] = nb;
          end else begin
            list_head = nb;
          end
        end
      end
      rrl_pkg::OP_SWITCH: begin
        n_switch++;
        if (run_slot != NIL) begin
          slot_ctx[run_slot[5:0]] = it.ctx;
          pick = fwd_link[run_slot[5:0]];
          if (pick == NIL) begin
            pick = list_head;
          end
        end else begin
          idle_ctx = it.ctx;
          pick     = list_head;
        end
        if (pick == NIL) begin
          run_slot   = NIL;
          res.valid  = 1'b0;
          res.thread = '0;
          res.ctx    = idle_ctx;
          res.slice  = '0;
          n_idle_picks++;
        end else begin
          run_slot = pick;
          if (!slot_awake[pick[5:0]]) begin
            n_stale_picks++;
          end
          // The counter is exactly SLICE_BITS wide, so the add wraps by itself.
          slot_slices[pick[5:0]] = slot_slices[pick[5:0]] + 1'b1;
          res.valid  = 1'b1;
          res.thread = pick[5:0];
          res.ctx    = slot_ctx[pick[5:0]];
          res.slice  = slot_slices[pick[5:0]];
        end
        expected_picks.push_back(res);
      end
      default: begin
        n_unused++;
      end
    endcase
  endtask

  task automatic queue_item(input logic [rrl_pkg::OP_W-1:0] op,
                            input logic [rrl_pkg::TID_W-1:0] tid,
                            input logic [rrl_pkg::CTX_W-1:0] ctx);
    sched_item_t it;
    it.op  = op;
    it.tid = tid;
    it.ctx = ctx;
    item_backlog.push_back(it);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: offer the backlog in bursts of random length, separated by random
  // gaps. An offered item is held steady until its transfer completes.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin : drive_proc
    logic offer;
    if (rst_ni) begin
      offer = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        apply_sched_item(item_backlog.pop_front());
        offer = 1'b0;
        if (burst_left > 0) begin
          burst_left--;
        end
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          // A quarter of the bursts run straight on with no gap at all.
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          offer = 1'b0;
        end else if (item_backlog.size() > 0) begin
          offer        = 1'b1;
          s_axis_tdata <= {2'b00, item_backlog[0].ctx, item_backlog[0].tid};
          s_axis_tuser <= item_backlog[0].op;
        end else begin
          offer = 1'b0;
        end
      end
      s_axis_tvalid <= offer;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: back-pressure whose mode is redrawn at random among free, choppy and stalling.
  // ---------------------------------------------------------------------------
  sink_mode_e  sink_mode  = SINK_FREE;
  int unsigned mode_left  = 0;
  int unsigned stall_left = 0;

  always @(posedge clk_i) begin : sink_proc
    if (rst_ni) begin
      if (mode_left == 0) begin
        sink_mode = sink_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (sink_mode)
          SINK_FREE:   m_axis_tready <= 1'b1;
          SINK_CHOPPY: m_axis_tready <= 1'($urandom_range(0, 1));
          default: begin
            if ($urandom_range(0, 5) == 0) begin
              stall_left = $urandom_range(1, 30);
              m_axis_tready <= 1'b0;
            end else begin
              m_axis_tready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: match every result transfer against the oldest expected pick.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_proc
    rrl_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_picks.size() == 0) begin
        $error("result transfer with no switch outstanding: tuser %h tdata %h",
               m_axis_tuser, m_axis_tdata);
        n_errors++;
      end else begin
        want = expected_picks.pop_front();
        n_checked++;
        if (m_axis_tuser[0] !== want.valid) begin
          $error("thread_valid: expected %0d, actual %0d", want.valid, m_axis_tuser[0]);
          n_errors++;
        end
        if (m_axis_tdata[5:0] !== want.thread) begin
          $error("chosen_thread: expected %0d, actual %0d", want.thread, m_axis_tdata[5:0]);
          n_errors++;
        end
        if (m_axis_tdata[69:6] !== want.ctx) begin
          $error("resume_context: expected %h, actual %h", want.ctx, m_axis_tdata[69:6]);
          n_errors++;
        end
        if (m_axis_tdata[101:70] !== want.slice) begin
          $error("slice_count: expected %0d, actual %0d", want.slice, m_axis_tdata[101:70]);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: far beyond the slowest legal run, sweep after reset included.
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin : stimulus_proc
    int unsigned               k;
    int unsigned               pool_hi;
    int unsigned               wake_pct;
    int unsigned               sleep_pct;
    int unsigned               r;
    logic [rrl_pkg::OP_W-1:0]  op;
    logic [rrl_pkg::CTX_W-1:0] ctx;

    foreach (slot_awake[i]) begin
      slot_awake[i]  = 1'b0;
      fwd_link[i]    = '0;
      back_link[i]   = '0;
      slot_ctx[i]    = '0;
      slot_slices[i] = '0;
    end

    // Directed opening: empty list, no-op cases, then a list that is switched
    // through while its running slot and that slot's successor fall asleep.
    queue_item(rrl_pkg::OP_SWITCH, 6'd0,  '1);           // nothing awake: idle context
    queue_item(rrl_pkg::OP_SLEEP,  6'd0,  '0);           // sleep of a sleeping slot
    queue_item(OP_UNUSED,          6'd63, 64'h0123_4567_89AB_CDEF);
    queue_item(rrl_pkg::OP_WAKE,   6'd63, '0);
    queue_item(rrl_pkg::OP_WAKE,   6'd63, {32{2'b10}});  // already awake: keep old context
    queue_item(rrl_pkg::OP_WAKE,   6'd0,  '1);
    queue_item(rrl_pkg::OP_WAKE,   6'd42, {32{2'b01}});
    queue_item(rrl_pkg::OP_SWITCH, 6'd0,  64'd1);        // from idle: take the head
    queue_item(rrl_pkg::OP_SWITCH, 6'd63, 64'hFEDC_BA98_7654_3210);
    queue_item(rrl_pkg::OP_SLEEP,  6'd0,  '0);           // sleep the running slot
    queue_item(rrl_pkg::OP_SWITCH, 6'd0,  {16{4'hC}});   // follow its old successor
    queue_item(rrl_pkg::OP_SWITCH, 6'd0,  {16{4'h3}});   // end of list: back to the head
    queue_item(rrl_pkg::OP_SLEEP,  6'd63, '0);
    queue_item(rrl_pkg::OP_SLEEP,  6'd42, '0);
    // Old link into a sleeping slot, then an empty list: idle.
    queue_item(rrl_pkg::OP_SWITCH, 6'd0,  64'h8000_0000_0000_0001);
    queue_item(rrl_pkg::OP_SWITCH, 6'd0,  64'h7FFF_FFFF_FFFF_FFFE);
    queue_item(rrl_pkg::OP_SWITCH, 6'd63, '0);
    queue_item(rrl_pkg::OP_WAKE,   6'd21, '1);
    queue_item(rrl_pkg::OP_SWITCH, 6'd0,  64'h5A5A_5A5A_5A5A_5A5A);
    // Lone slot picks itself again.
    queue_item(rrl_pkg::OP_SWITCH, 6'd0,  64'hA5A5_A5A5_A5A5_A5A5);
    queue_item(OP_UNUSED,          6'd0,  '0);
    queue_item(rrl_pkg::OP_SLEEP,  6'd21, '0);
    queue_item(rrl_pkg::OP_WAKE,   6'd21, 64'h0000_0000_FFFF_FFFF);
    queue_item(rrl_pkg::OP_SWITCH, 6'd42, 64'hFFFF_FFFF_0000_0000);

    // Random traffic in phases: each phase picks a slot window and a mix, so
    // that some phases grow long lists and others drain them to empty.
    pool_hi   = 63;
    wake_pct  = 40;
    sleep_pct = 25;
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 100 == 0) begin
        case ($urandom_range(0, 3))
          0:       pool_hi = 3;
          1:       pool_hi = 7;
          2:       pool_hi = 15;
          default: pool_hi = 63;
        endcase
        wake_pct  = $urandom_range(20, 50);
        sleep_pct = $urandom_range(15, 35);
      end
      r = $urandom_range(0, 99);
      if (r < wake_pct) begin
        op = rrl_pkg::OP_WAKE;
      end else if (r < wake_pct + sleep_pct) begin
        op = rrl_pkg::OP_SLEEP;
      end else if (r < 96) begin
        op = rrl_pkg::OP_SWITCH;
      end else begin
        op = OP_UNUSED;
      end
      case ($urandom_range(0, 9))
        0:       ctx = '1;
        1:       ctx = '0;
        default: ctx = {$urandom(), $urandom()};
      endcase
      queue_item(op, 6'($urandom_range(0, pool_hi)), ctx);
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: every item transferred, then every pick seen, then a short tail
    // so that a stray extra result still has time to show up.
    while (item_backlog.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_picks.size() > 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("Covered %0d wakes, %0d sleeps, %0d switches and %0d unused codes.",
             n_wake, n_sleep, n_switch, n_unused);
    $display("Checked %0d picks: %0d idle, %0d through a stale link; %0d mismatches.",
             n_checked, n_idle_picks, n_stale_picks, n_errors);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
